@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the point height variance block.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/phv_pkg.sv @@
// Package for the point height variance block: widths, register map and types.
// No dependencies; used by the interfaces and every module of the block.
package phv_pkg;

   // Field and register widths.
   localparam int POINT_WIDTH     = 16;
   localparam int COEF_FRAC_BITS  = 19;
   localparam int SLOT_BITS       = 21;
   localparam int REG_WIDTH       = 3 * SLOT_BITS;
   localparam int NUM_REGS        = 7;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int REG_INDEX_LSB   = 3;
   localparam int REG_INDEX_WIDTH = 3;
   localparam int CSR_ADDR_WIDTH  = REG_INDEX_LSB + REG_INDEX_WIDTH;
   localparam int OUT_WIDTH       = 48;

   // Rounding constants: half of one output unit before a right shift.
   localparam int COEF_HALF = 1 << (COEF_FRAC_BITS - 1);
   localparam int OUT_SHIFT = 8;
   localparam int OUT_HALF  = 1 << (OUT_SHIFT - 1);

   // Datapath widths, each just wide enough for the values it carries.
   localparam int PROD1_WIDTH = SLOT_BITS + POINT_WIDTH;
   localparam int ACC1_WIDTH  = PROD1_WIDTH + 2;
   localparam int ROT_WIDTH   = ACC1_WIDTH - COEF_FRAC_BITS;
   localparam int BASE_WIDTH  = ((ROT_WIDTH > SLOT_BITS) ? ROT_WIDTH : SLOT_BITS) + 1;
   localparam int PROD2_WIDTH = SLOT_BITS + BASE_WIDTH;
   localparam int DIFF_WIDTH  = PROD2_WIDTH + 2;
   localparam int JAC_WIDTH   = DIFF_WIDTH - COEF_FRAC_BITS;
   localparam int COV_WIDTH   = SLOT_BITS + 1;
   localparam int CJ_WIDTH    = COV_WIDTH + JAC_WIDTH;
   localparam int W_WIDTH     = CJ_WIDTH + 2;
   localparam int W_SPLIT     = W_WIDTH / 2;
   localparam int W_HI_WIDTH  = W_WIDTH - W_SPLIT;
   localparam int PP_WIDTH    = JAC_WIDTH + W_SPLIT + 1;
   localparam int TERM_WIDTH  = JAC_WIDTH + W_WIDTH;
   localparam int Q_WIDTH     = TERM_WIDTH + 2;

   // Pipeline depths of the two halves.
   localparam int FRONT_STAGES = 4;
   localparam int QUAD_STAGES  = 6;

   // Register map, one 64-bit word per register.
   localparam logic [REG_INDEX_WIDTH-1:0] REG_ROT_ROW0    = REG_INDEX_WIDTH'(0);
   localparam logic [REG_INDEX_WIDTH-1:0] REG_ROT_ROW1    = REG_INDEX_WIDTH'(1);
   localparam logic [REG_INDEX_WIDTH-1:0] REG_ROT_ROW2    = REG_INDEX_WIDTH'(2);
   localparam logic [REG_INDEX_WIDTH-1:0] REG_OFFSET      = REG_INDEX_WIDTH'(3);
   localparam logic [REG_INDEX_WIDTH-1:0] REG_HEIGHT_AXIS = REG_INDEX_WIDTH'(4);
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COV_DIAG    = REG_INDEX_WIDTH'(5);
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COV_OFF     = REG_INDEX_WIDTH'(6);
   localparam logic [REG_INDEX_WIDTH-1:0] REG_UNMAPPED    = REG_INDEX_WIDTH'(7);

   // Geometry settings: slot k of each vector is element k.
   typedef struct packed {
      logic [2:0][2:0][SLOT_BITS-1:0] rot;
      logic [2:0][SLOT_BITS-1:0]      offset;
      logic [2:0][SLOT_BITS-1:0]      axis;
   } phv_geom_type;

   // Rotation covariance: unsigned diagonal, signed xy, xz, yz terms.
   typedef struct packed {
      logic [2:0][SLOT_BITS-1:0] diag;
      logic [2:0][SLOT_BITS-1:0] off;
   } phv_cov_type;

   // Height Jacobian, three signed entries in whole millimetres.
   typedef logic [2:0][JAC_WIDTH-1:0] jac_vec_type;

endpackage

@@ rtl/phv_req_if.sv @@
// Request channel of the point height variance block: one point per request.
// Depends on phv_pkg for the point width.
interface phv_req_if;
   import phv_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [POINT_WIDTH-1:0] point_x;
   logic signed [POINT_WIDTH-1:0] point_y;
   logic signed [POINT_WIDTH-1:0] point_z;
   logic                          last_point;

   modport source (output valid, point_x, point_y, point_z, last_point, input ready);
   modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

@@ rtl/phv_rsp_if.sv @@
// Response channel of the point height variance block: one variance per request.
// Depends on phv_pkg for the result width.
interface phv_rsp_if;
   import phv_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_WIDTH-1:0] height_var;
   logic                 last_result;

   modport source (output valid, height_var, last_result, input ready);
   modport sink (input valid, height_var, last_result, output ready);
endinterface

@@ rtl/phv_front.sv @@
// Front half of the pipeline: sensor-to-base transform and height Jacobian.
// Depends on phv_pkg; four register stages with per-stage valid bits.
module phv_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [phv_pkg::POINT_WIDTH-1:0] in_x,
   input  logic signed [phv_pkg::POINT_WIDTH-1:0] in_y,
   input  logic signed [phv_pkg::POINT_WIDTH-1:0] in_z,
   input  logic                                  in_last,
   input  phv_pkg::phv_geom_type                 geom,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output phv_pkg::jac_vec_type                  out_jac,
   output logic                                  out_last
);
   import phv_pkg::*;

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;
   logic [FRONT_STAGES-1:0] advance;
   logic [FRONT_STAGES-1:0] last_ff;

   logic signed [POINT_WIDTH-1:0] point [3];
   logic signed [PROD1_WIDTH-1:0] prod_in [3][3];
   logic signed [PROD1_WIDTH-1:0] prod_ff [3][3];
   logic signed [ACC1_WIDTH-1:0]  acc [3];
   logic signed [ACC1_WIDTH-1:0]  acc_shift [3];
   logic signed [BASE_WIDTH-1:0]  base_in [3];
   logic signed [BASE_WIDTH-1:0]  base_ff [3];
   logic signed [PROD2_WIDTH-1:0] hb_in [3][2];
   logic signed [PROD2_WIDTH-1:0] hb_ff [3][2];
   logic signed [DIFF_WIDTH-1:0]  diff [3];
   logic signed [DIFF_WIDTH-1:0]  diff_shift [3];
   jac_vec_type                   jac_in, jac_ff;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      advance[FRONT_STAGES-1] = !valid_ff[FRONT_STAGES-1] || out_ready;
      for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
      valid_in[0] = advance[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < FRONT_STAGES; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign in_ready  = advance[0];
   assign out_valid = valid_ff[FRONT_STAGES-1];
   assign out_jac   = jac_ff;
   assign out_last  = last_ff[FRONT_STAGES-1];

   assign point[0] = in_x;
   assign point[1] = in_y;
   assign point[2] = in_z;

   // Stage 1: the nine products of the rotation with the point.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = $signed(geom.rot[r][k]) * point[k];
         end
      end
   end

   // Stage 2: row sums rounded to whole millimetres, plus the sensor offset.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = ACC1_WIDTH'(prod_ff[r][0]) + ACC1_WIDTH'(prod_ff[r][1])
                + ACC1_WIDTH'(prod_ff[r][2]) + ACC1_WIDTH'(COEF_HALF);
         acc_shift[r] = acc[r] >>> COEF_FRAC_BITS;
         base_in[r] = BASE_WIDTH'(acc_shift[r]) + BASE_WIDTH'($signed(geom.offset[r]));
      end
   end

   // Stage 3: axis times skew matrix, as a positive and a negative product per entry.
   always_comb begin
      hb_in[0][0] = $signed(geom.axis[1]) * base_ff[2];
      hb_in[0][1] = $signed(geom.axis[2]) * base_ff[1];
      hb_in[1][0] = $signed(geom.axis[2]) * base_ff[0];
      hb_in[1][1] = $signed(geom.axis[0]) * base_ff[2];
      hb_in[2][0] = $signed(geom.axis[0]) * base_ff[1];
      hb_in[2][1] = $signed(geom.axis[1]) * base_ff[0];
   end

   // Stage 4: difference rounded to whole millimetres. The entries stay far
   // below the Jacobian limit of 2^25 - 1 mm, so no clamp is needed.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = DIFF_WIDTH'(hb_ff[k][0]) - DIFF_WIDTH'(hb_ff[k][1])
                 + DIFF_WIDTH'(COEF_HALF);
         diff_shift[k] = diff[k] >>> COEF_FRAC_BITS;
         jac_in[k] = JAC_WIDTH'(diff_shift[k]);
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers load whenever their stage moves.
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         prod_ff    <= prod_in;
         last_ff[0] <= in_last;
      end
      if (advance[1]) begin
         base_ff    <= base_in;
         last_ff[1] <= last_ff[0];
      end
      if (advance[2]) begin
         hb_ff      <= hb_in;
         last_ff[2] <= last_ff[1];
      end
      if (advance[3]) begin
         jac_ff     <= jac_in;
         last_ff[3] <= last_ff[2];
      end
   end

endmodule

@@ rtl/phv_quad.sv @@
// Back half of the pipeline: quadratic form of the Jacobian with the covariance.
// Depends on phv_pkg; six register stages, the last one is the output register.
module phv_quad (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  phv_pkg::jac_vec_type              in_jac,
   input  logic                              in_last,
   input  phv_pkg::phv_cov_type              cov,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [phv_pkg::OUT_WIDTH-1:0]     out_var,
   output logic                              out_last
);
   import phv_pkg::*;

   logic [QUAD_STAGES-1:0] valid_ff, valid_in;
   logic [QUAD_STAGES-1:0] advance;
   logic [QUAD_STAGES-1:0] last_ff;

   logic signed [COV_WIDTH-1:0]  c_mat [3][3];
   logic signed [CJ_WIDTH-1:0]   cj_in [3][3];
   logic signed [CJ_WIDTH-1:0]   cj_ff [3][3];
   jac_vec_type                  jac0_ff, jac1_ff;
   logic signed [W_WIDTH-1:0]    w_in [3];
   logic signed [W_WIDTH-1:0]    w_ff [3];
   logic signed [PP_WIDTH-1:0]   pp_lo_in [3];
   logic signed [PP_WIDTH-1:0]   pp_lo_ff [3];
   logic signed [PP_WIDTH-1:0]   pp_hi_in [3];
   logic signed [PP_WIDTH-1:0]   pp_hi_ff [3];
   logic signed [TERM_WIDTH-1:0] term_in [3];
   logic signed [TERM_WIDTH-1:0] term_ff [3];
   logic signed [Q_WIDTH-1:0]    q_in, q_ff;
   logic signed [Q_WIDTH-1:0]    q_round;
   logic signed [Q_WIDTH-1:0]    q_shift;
   logic [OUT_WIDTH-1:0]         var_in, var_ff;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      advance[QUAD_STAGES-1] = !valid_ff[QUAD_STAGES-1] || out_ready;
      for (int k = QUAD_STAGES - 2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
      valid_in[0] = advance[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < QUAD_STAGES; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign in_ready  = advance[0];
   assign out_valid = valid_ff[QUAD_STAGES-1];
   assign out_var   = var_ff;
   assign out_last  = last_ff[QUAD_STAGES-1];

   // Symmetric covariance matrix; the diagonal is unsigned.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_mat[k][k] = $signed({1'b0, cov.diag[k]});
      end
      c_mat[0][1] = COV_WIDTH'($signed(cov.off[0]));
      c_mat[1][0] = COV_WIDTH'($signed(cov.off[0]));
      c_mat[0][2] = COV_WIDTH'($signed(cov.off[1]));
      c_mat[2][0] = COV_WIDTH'($signed(cov.off[1]));
      c_mat[1][2] = COV_WIDTH'($signed(cov.off[2]));
      c_mat[2][1] = COV_WIDTH'($signed(cov.off[2]));
   end

   // Stage 1: covariance entries times Jacobian entries.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            cj_in[r][k] = c_mat[r][k] * $signed(in_jac[k]);
         end
      end
   end

   // Stage 2: row sums give w = C j.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         w_in[r] = W_WIDTH'(cj_ff[r][0]) + W_WIDTH'(cj_ff[r][1]) + W_WIDTH'(cj_ff[r][2]);
      end
   end

   // Stage 3: j times w, split into a low and a high partial product.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pp_lo_in[k] = $signed(jac1_ff[k]) * $signed({1'b0, w_ff[k][W_SPLIT-1:0]});
         pp_hi_in[k] = $signed(jac1_ff[k]) * $signed(w_ff[k][W_WIDTH-1:W_SPLIT]);
      end
   end

   // Stage 4: recombine the partial products of each term.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k] = (TERM_WIDTH'(pp_hi_ff[k]) <<< W_SPLIT) + TERM_WIDTH'(pp_lo_ff[k]);
      end
   end

   // Stage 5: sum of the three terms, exact.
   assign q_in = Q_WIDTH'(term_ff[0]) + Q_WIDTH'(term_ff[1]) + Q_WIDTH'(term_ff[2]);

   // Stage 6: negative forms give zero, else round, rescale and saturate.
   always_comb begin
      q_round = q_ff + Q_WIDTH'(OUT_HALF);
      q_shift = q_round >>> OUT_SHIFT;
      if (q_ff[Q_WIDTH-1]) begin
         var_in = '0;
      end else if (|q_shift[Q_WIDTH-1:OUT_WIDTH]) begin
         var_in = '1;
      end else begin
         var_in = q_shift[OUT_WIDTH-1:0];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers load whenever their stage moves.
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         cj_ff      <= cj_in;
         jac0_ff    <= in_jac;
         last_ff[0] <= in_last;
      end
      if (advance[1]) begin
         w_ff       <= w_in;
         jac1_ff    <= jac0_ff;
         last_ff[1] <= last_ff[0];
      end
      if (advance[2]) begin
         pp_lo_ff   <= pp_lo_in;
         pp_hi_ff   <= pp_hi_in;
         last_ff[2] <= last_ff[1];
      end
      if (advance[3]) begin
         term_ff    <= term_in;
         last_ff[3] <= last_ff[2];
      end
      if (advance[4]) begin
         q_ff       <= q_in;
         last_ff[4] <= last_ff[3];
      end
      if (advance[5]) begin
         var_ff     <= var_in;
         last_ff[5] <= last_ff[4];
      end
   end

endmodule

@@ rtl/point_height_variance.sv @@
// Point height variance: one point in, one height variance out, through ten
// register stages (four transform, six quadratic form). Throughput is one point
// per cycle, as every product stage has its own multipliers, and the input stalls
// only when all ten stages hold items and the output is held. Synchronous reset
// clears the valid bits and the settings registers. Uses phv_pkg, phv_front,
// phv_quad.
`include "assert_macros.svh"

module point_height_variance (
   input  logic                                 clock,
   input  logic                                 reset,
   phv_req_if.sink                              req,
   phv_rsp_if.source                            rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [phv_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [phv_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [phv_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import phv_pkg::*;

   logic [REG_WIDTH-1:0]       regs_ff [NUM_REGS];
   logic [REG_WIDTH-1:0]       regs_in [NUM_REGS];
   logic                       csr_write;
   logic [REG_INDEX_WIDTH-1:0] csr_index;
   phv_geom_type               geom;
   phv_cov_type                cov;
   logic                       mid_valid;
   logic                       mid_ready;
   jac_vec_type                mid_jac;
   logic                       mid_last;

   // Register port: no wait states, one 64-bit word per register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:REG_INDEX_LSB];

   // Register write decode; writes to the unmapped word are dropped.
   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         unique case (csr_index) inside
            REG_ROT_ROW0, REG_ROT_ROW1, REG_ROT_ROW2, REG_OFFSET,
            REG_HEIGHT_AXIS, REG_COV_DIAG, REG_COV_OFF: begin
               regs_in[csr_index] = csr_pwdata[REG_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Register read decode.
   always_comb begin
      unique case (csr_index) inside
         REG_ROT_ROW0, REG_ROT_ROW1, REG_ROT_ROW2, REG_OFFSET,
         REG_HEIGHT_AXIS, REG_COV_DIAG, REG_COV_OFF: begin
            csr_prdata = CSR_DATA_WIDTH'(regs_ff[csr_index]);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Settings as seen by the datapath; the slot layout matches the packed arrays.
   always_comb begin
      geom.rot[0] = regs_ff[REG_ROT_ROW0];
      geom.rot[1] = regs_ff[REG_ROT_ROW1];
      geom.rot[2] = regs_ff[REG_ROT_ROW2];
      geom.offset = regs_ff[REG_OFFSET];
      geom.axis   = regs_ff[REG_HEIGHT_AXIS];
      cov.diag    = regs_ff[REG_COV_DIAG];
      cov.off     = regs_ff[REG_COV_OFF];
   end

   // Transform and Jacobian.
   phv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_x      (req.point_x),
      .in_y      (req.point_y),
      .in_z      (req.point_z),
      .in_last   (req.last_point),
      .geom      (geom),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_jac   (mid_jac),
      .out_last  (mid_last)
   );

   // Quadratic form and output register.
   phv_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_jac    (mid_jac),
      .in_last   (mid_last),
      .cov       (cov),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_var   (rsp.height_var),
      .out_last  (rsp.last_result)
   );

   // The pipeline only refuses a request when a finished result is waiting.
   `ASSERT_IMPLIES(a_stall_needs_result, clock, reset, !req.ready, rsp.valid)
   // A write to the unmapped word leaves every register untouched.
   `ASSERT_NEXT(a_unmapped_write_dropped, clock, reset, csr_write && (csr_index == REG_UNMAPPED), $stable({regs_ff[0], regs_ff[1], regs_ff[2], regs_ff[3], regs_ff[4], regs_ff[5], regs_ff[6]}))
   // A write to the height axis lands with the top data bit dropped.
   `ASSERT_NEXT(a_axis_write_lands, clock, reset, csr_write && (csr_index == REG_HEIGHT_AXIS), regs_ff[REG_HEIGHT_AXIS] == $past(csr_pwdata[REG_WIDTH-1:0]))

endmodule
